/* src/sec_pkg.sv */
`default_nettype none
package sec_pkg;

  localparam int CW    = 32;
  localparam int FB    = 16;
  localparam int PW    = 32;
  localparam int STEPS = 30;
  localparam int DW    = CW + 1;
  localparam int VW    = 44;
  localparam int RW    = 34;

  localparam logic [2:0] OP_LEN_ANGLE = 3'd0;
  localparam logic [2:0] OP_CENTRED   = 3'd1;
  localparam logic [2:0] OP_THRU_PAR  = 3'd2;
  localparam logic [2:0] OP_THRU_PERP = 3'd3;
  localparam logic [2:0] OP_CONG_PAR  = 3'd4;
  localparam logic [2:0] OP_CONG_PERP = 3'd5;
  localparam logic [2:0] OP_FOOT      = 3'd6;
  localparam logic [2:0] OP_TOWARD    = 3'd7;

  localparam logic [PW-1:0] QUARTER = 32'h4000_0000;
  localparam logic [PW-1:0] HALF    = 32'h8000_0000;

  localparam logic [45:0] TURN_PER_RAD = 46'd44798133900178;
  localparam int KSPLIT = 23;
  localparam logic [KSPLIT-1:0] K_LO = TURN_PER_RAD[KSPLIT-1:0];
  localparam logic [KSPLIT-1:0] K_HI = TURN_PER_RAD[2*KSPLIT-1:KSPLIT];

  localparam logic [31:0] DEG_MOD   = 32'(360 << FB);
  localparam logic [31:0] DEG_WRAP  = 32'(64'd92 * 64'(DEG_MOD));
  localparam logic [31:0] DEG_MULT  = 32'(65536 / 360);
  localparam logic [26:0] DEG_RECIP = 27'd95443718;

  localparam logic signed [RW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [RW-1:0] ONE_Q30  = 34'sd1073741824;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [VW-1:0] vec_t;
  typedef logic signed [RW-1:0] rot_t;
  typedef logic [PW-1:0] phase_t;

  typedef struct packed {
    logic [2:0] op;
    logic       deg;
    coord_t     px;
    coord_t     py;
    coord_t     len;
    coord_t     ang;
    coord_t     sx1;
    coord_t     sy1;
    coord_t     sx2;
    coord_t     sy2;
    coord_t     tx;
    coord_t     ty;
  } input_t;

  typedef struct packed {
    logic [2:0] op;
    logic       ok;
    coord_t     px;
    coord_t     py;
    coord_t     len;
    coord_t     sx1;
    coord_t     sy1;
  } ctx_t;

  typedef struct packed {
    ctx_t   ctx;
    phase_t aphase;
    logic   spec;
    phase_t sphase;
    vec_t   x;
    vec_t   y;
    phase_t z;
  } vstate_t;

  typedef struct packed {
    ctx_t ctx;
    rot_t c;
    rot_t s;
  } dir_t;

  function automatic diff_t dsub(input coord_t a, input coord_t b);
    return {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic phase_t atan_phase(input int unsigned i);
    phase_t a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      24: a = 32'h00000028;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000002;
      default: a = 32'h00000001;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

/* src/sec_front.sv */
`default_nettype none
module sec_front
  import sec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  input_t  in_item,
  output logic    out_valid,
  output vstate_t out_state
);

  localparam int MW = 41;

  // stage 1: differences, special directions, angle products
  diff_t sdx, sdy, tdx, tdy, dx, dy;
  logic zero_vec, fail, spec;
  phase_t sph;
  logic [31:0] aplus;
  logic signed [55:0] plo, phi;
  ctx_t ctx;

  always_comb begin
    sdx = dsub(in_item.sx2, in_item.sx1);
    sdy = dsub(in_item.sy2, in_item.sy1);
    tdx = dsub(in_item.tx, in_item.px);
    tdy = dsub(in_item.ty, in_item.py);
    dx = (in_item.op == OP_TOWARD) ? tdx : sdx;
    dy = (in_item.op == OP_TOWARD) ? tdy : sdy;
    zero_vec = (dx == '0) && (dy == '0);
    fail = ((in_item.op == OP_FOOT) || (in_item.op == OP_TOWARD)) && zero_vec;
    spec = (dx == '0) || (dy == '0);
    if (dy == '0) begin
      sph = dx[DW-1] ? HALF : '0;
    end else if (dy[DW-1]) begin
      sph = HALF | QUARTER;
    end else begin
      sph = QUARTER;
    end
    aplus = in_item.ang + (in_item.ang[CW-1] ? DEG_WRAP : 32'd0);
    plo = $signed(in_item.ang) * $signed({1'b0, K_LO});
    phi = $signed(in_item.ang) * $signed({1'b0, K_HI});
    ctx.op = in_item.op;
    ctx.ok = !fail;
    ctx.px = in_item.px;
    ctx.py = in_item.py;
    ctx.len = in_item.len;
    ctx.sx1 = in_item.sx1;
    ctx.sy1 = in_item.sy1;
  end

  logic f1_valid, f1_deg, f1_spec;
  ctx_t f1_ctx;
  diff_t f1_dx, f1_dy;
  phase_t f1_sph;
  logic [31:0] f1_aplus;
  logic signed [55:0] f1_plo, f1_phi;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
    if (en) begin
      f1_ctx <= ctx;
      f1_deg <= in_item.deg;
      f1_dx <= dx;
      f1_dy <= dy;
      f1_spec <= spec;
      f1_sph <= sph;
      f1_aplus <= aplus;
      f1_plo <= plo;
      f1_phi <= phi;
    end
  end

  // stage 2: radian phase sum, upper modulo steps, magnitudes
  logic signed [63:0] rfull;
  logic [31:0] r2;
  logic [DW-1:0] ax, ay;

  always_comb begin
    rfull = (64'(f1_phi) <<< KSPLIT) + 64'(f1_plo);
    r2 = f1_aplus;
    for (int k = 6; k >= 4; k--) begin
      if (r2 >= (DEG_MOD << k)) begin
        r2 = r2 - (DEG_MOD << k);
      end
    end
    ax = f1_dx[DW-1] ? -f1_dx : f1_dx;
    ay = f1_dy[DW-1] ? -f1_dy : f1_dy;
  end

  logic f2_valid, f2_deg, f2_spec;
  ctx_t f2_ctx;
  phase_t f2_sph, f2_rph;
  logic [31:0] f2_r;
  vec_t f2_x, f2_y;
  logic [MW-1:0] f2_mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (en) begin
      f2_valid <= f1_valid;
    end
    if (en) begin
      f2_ctx <= f1_ctx;
      f2_deg <= f1_deg;
      f2_spec <= f1_spec;
      f2_sph <= f1_sph;
      f2_rph <= rfull[63:32];
      f2_r <= r2;
      f2_x <= VW'(f1_dx);
      f2_y <= VW'(f1_dy);
      f2_mx <= MW'((ax > ay) ? ax : ay);
    end
  end

  // stage 3: lower modulo steps, coarse normalize
  logic [31:0] r3;
  vec_t x3, y3;
  logic [MW-1:0] m3;

  always_comb begin
    r3 = f2_r;
    for (int k = 3; k >= 0; k--) begin
      if (r3 >= (DEG_MOD << k)) begin
        r3 = r3 - (DEG_MOD << k);
      end
    end
    x3 = f2_x;
    y3 = f2_y;
    m3 = f2_mx;
    if (m3 < (41'd1 << 8)) begin
      m3 = m3 << 32;
      x3 = x3 <<< 32;
      y3 = y3 <<< 32;
    end
    if (m3 < (41'd1 << 24)) begin
      m3 = m3 << 16;
      x3 = x3 <<< 16;
      y3 = y3 <<< 16;
    end
  end

  logic f3_valid, f3_deg, f3_spec;
  ctx_t f3_ctx;
  phase_t f3_sph, f3_rph;
  logic [31:0] f3_r;
  vec_t f3_x, f3_y;
  logic [MW-1:0] f3_mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else if (en) begin
      f3_valid <= f2_valid;
    end
    if (en) begin
      f3_ctx <= f2_ctx;
      f3_deg <= f2_deg;
      f3_spec <= f2_spec;
      f3_sph <= f2_sph;
      f3_rph <= f2_rph;
      f3_r <= r3;
      f3_x <= x3;
      f3_y <= y3;
      f3_mx <= m3;
    end
  end

  // stage 4: degree scaling products, mid normalize
  logic [52:0] qprod;
  vec_t x4, y4;
  logic [MW-1:0] m4;

  always_comb begin
    qprod = 53'({f3_r[24:0], 1'b0}) * 53'(DEG_RECIP);
    x4 = f3_x;
    y4 = f3_y;
    m4 = f3_mx;
    if (m4 < (41'd1 << 32)) begin
      m4 = m4 << 8;
      x4 = x4 <<< 8;
      y4 = y4 <<< 8;
    end
    if (m4 < (41'd1 << 36)) begin
      m4 = m4 << 4;
      x4 = x4 <<< 4;
      y4 = y4 <<< 4;
    end
  end

  logic f4_valid, f4_deg, f4_spec;
  ctx_t f4_ctx;
  phase_t f4_sph, f4_rph;
  logic [31:0] f4_p182;
  logic [20:0] f4_q;
  vec_t f4_x, f4_y;
  logic [MW-1:0] f4_mx;

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_valid <= 1'b0;
    end else if (en) begin
      f4_valid <= f3_valid;
    end
    if (en) begin
      f4_ctx <= f3_ctx;
      f4_deg <= f3_deg;
      f4_spec <= f3_spec;
      f4_sph <= f3_sph;
      f4_rph <= f3_rph;
      f4_p182 <= f3_r * DEG_MULT;
      f4_q <= qprod[52:32];
      f4_x <= x4;
      f4_y <= y4;
      f4_mx <= m4;
    end
  end

  // stage 5: angle phase, fine normalize
  vec_t x5, y5;
  logic [MW-1:0] m5;

  always_comb begin
    x5 = f4_x;
    y5 = f4_y;
    m5 = f4_mx;
    if (m5 < (41'd1 << 38)) begin
      m5 = m5 << 2;
      x5 = x5 <<< 2;
      y5 = y5 <<< 2;
    end
    if (m5 < (41'd1 << 39)) begin
      x5 = x5 <<< 1;
      y5 = y5 <<< 1;
    end
  end

  logic f5_valid, f5_spec;
  ctx_t f5_ctx;
  phase_t f5_sph, f5_aph;
  vec_t f5_x, f5_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      f5_valid <= 1'b0;
    end else if (en) begin
      f5_valid <= f4_valid;
    end
    if (en) begin
      f5_ctx <= f4_ctx;
      f5_spec <= f4_spec;
      f5_sph <= f4_sph;
      f5_aph <= f4_deg ? (f4_p182 + 32'(f4_q)) : f4_rph;
      f5_x <= x5;
      f5_y <= y5;
    end
  end

  // stage 6: fold into the right half plane
  vstate_t st6;

  always_comb begin
    st6.ctx = f5_ctx;
    st6.aphase = f5_aph;
    st6.spec = f5_spec;
    st6.sphase = f5_sph;
    if (f5_x[VW-1]) begin
      st6.x = -f5_x;
      st6.y = -f5_y;
      st6.z = HALF;
    end else begin
      st6.x = f5_x;
      st6.y = f5_y;
      st6.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f5_valid;
    end
    if (en) begin
      out_state <= st6;
    end
  end

endmodule
`default_nettype wire

/* src/sec_vector.sv */
`default_nettype none
module sec_vector
  import sec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  vstate_t in_state,
  output logic    out_valid,
  output vstate_t out_state
);

  vstate_t st [1:STEPS];
  logic    vld [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    vstate_t cur, nxt;
    logic    cur_v;

    if (i == 0) begin : g_first
      assign cur = in_state;
      assign cur_v = in_valid;
    end else begin : g_rest
      assign cur = st[i];
      assign cur_v = vld[i];
    end

    always_comb begin
      nxt = cur;
      if (!cur.y[VW-1] && (cur.y != '0)) begin
        nxt.x = $signed(cur.x) + ($signed(cur.y) >>> i);
        nxt.y = $signed(cur.y) - ($signed(cur.x) >>> i);
        nxt.z = cur.z + atan_phase(i);
      end else begin
        nxt.x = $signed(cur.x) - ($signed(cur.y) >>> i);
        nxt.y = $signed(cur.y) + ($signed(cur.x) >>> i);
        nxt.z = cur.z - atan_phase(i);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= cur_v;
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = vld[STEPS];
  assign out_state = st[STEPS];

endmodule
`default_nettype wire

/* src/sec_rotate.sv */
`default_nettype none
module sec_rotate
  import sec_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    en,
  input  logic    in_valid,
  input  vstate_t in_state,
  output logic    out_valid,
  output dir_t    out_dir
);

  typedef struct packed {
    ctx_t               ctx;
    logic [1:0]         q;
    logic               axis;
    rot_t               x;
    rot_t               y;
    logic signed [31:0] z;
  } rstate_t;

  // phase select and seed
  phase_t ph;
  rstate_t seed;

  always_comb begin
    if ((in_state.ctx.op == OP_LEN_ANGLE) || (in_state.ctx.op == OP_CENTRED)) begin
      ph = in_state.aphase;
    end else if (in_state.spec) begin
      ph = in_state.sphase;
    end else begin
      ph = in_state.z;
    end
    if ((in_state.ctx.op == OP_THRU_PERP) || (in_state.ctx.op == OP_CONG_PERP)) begin
      ph = ph + QUARTER;
    end
    seed.ctx = in_state.ctx;
    seed.q = ph[31:30];
    seed.axis = (ph[29:0] == '0);
    seed.x = GAIN_Q30;
    seed.y = '0;
    seed.z = {2'b00, ph[29:0]};
  end

  rstate_t st [0:STEPS];
  logic    vld [0:STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      st[0] <= seed;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    rstate_t nxt;

    always_comb begin
      nxt = st[i];
      if (!st[i].z[31]) begin
        nxt.x = $signed(st[i].x) - ($signed(st[i].y) >>> i);
        nxt.y = $signed(st[i].y) + ($signed(st[i].x) >>> i);
        nxt.z = st[i].z - $signed(atan_phase(i));
      end else begin
        nxt.x = $signed(st[i].x) + ($signed(st[i].y) >>> i);
        nxt.y = $signed(st[i].y) - ($signed(st[i].x) >>> i);
        nxt.z = st[i].z + $signed(atan_phase(i));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  // quadrant unfold
  rot_t fx, fy;
  dir_t dnext;

  always_comb begin
    fx = st[STEPS].axis ? ONE_Q30 : st[STEPS].x;
    fy = st[STEPS].axis ? '0 : st[STEPS].y;
    dnext.ctx = st[STEPS].ctx;
    case (st[STEPS].q)
      2'd0: begin
        dnext.c = fx;
        dnext.s = fy;
      end
      2'd1: begin
        dnext.c = -fy;
        dnext.s = fx;
      end
      2'd2: begin
        dnext.c = -fx;
        dnext.s = -fy;
      end
      default: begin
        dnext.c = fy;
        dnext.s = -fx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[STEPS];
    end
    if (en) begin
      out_dir <= dnext;
    end
  end

endmodule
`default_nettype wire

/* src/sec_finish.sv */
`default_nettype none
module sec_finish
  import sec_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  dir_t   in_dir,
  output logic   out_valid,
  output logic   ok,
  output coord_t end_x1,
  output coord_t end_y1,
  output coord_t end_x2,
  output coord_t end_y2
);

  localparam int PPW = DW + RW;
  localparam int UW  = 36;
  localparam int MPW = UW + RW;
  localparam int EW  = 40;

  localparam logic signed [PPW:0] RP29 = (PPW+1)'(64'd1 << 29);
  localparam logic signed [PPW:0] RP30 = (PPW+1)'(64'd1 << 30);
  localparam logic signed [MPW-1:0] RM29 = MPW'(64'd1 << 29);
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'd1 << (CW-1)) - 64'd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  function automatic logic signed [UW-1:0] rnd_p(input logic signed [PPW-1:0] p,
                                                  input logic by31);
    logic signed [PPW:0] pe;
    pe = {p[PPW-1], p};
    if (by31) begin
      pe = (pe + RP30) >>> 31;
    end else begin
      pe = (pe + RP29) >>> 30;
    end
    return pe[UW-1:0];
  endfunction

  function automatic logic signed [UW-1:0] rnd_m(input logic signed [MPW-1:0] p);
    logic signed [MPW-1:0] pe;
    pe = (p + RM29) >>> 30;
    return pe[UW-1:0];
  endfunction

  function automatic coord_t sat(input logic signed [EW-1:0] v);
    coord_t r;
    if (v > SAT_HI) begin
      r = SAT_HI[CW-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[CW-1:0];
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // stage a: multiplicands
  logic a_valid;
  ctx_t a_ctx;
  rot_t a_c, a_s;
  diff_t a_m1, a_m2;
  logic foot_in;

  assign foot_in = (in_dir.ctx.op == OP_FOOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_ctx <= in_dir.ctx;
      a_c <= in_dir.c;
      a_s <= in_dir.s;
      a_m1 <= foot_in ? dsub(in_dir.ctx.px, in_dir.ctx.sx1) : DW'(in_dir.ctx.len);
      a_m2 <= foot_in ? dsub(in_dir.ctx.py, in_dir.ctx.sy1) : DW'(in_dir.ctx.len);
    end
  end

  // stage b: first products
  logic b_valid;
  ctx_t b_ctx;
  rot_t b_c, b_s;
  logic signed [PPW-1:0] b_p1, b_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
    if (en) begin
      b_ctx <= a_ctx;
      b_c <= a_c;
      b_s <= a_s;
      b_p1 <= a_m1 * a_c;
      b_p2 <= a_m2 * a_s;
    end
  end

  // stage c: rounding, projection length
  logic centred, b_foot;
  logic signed [UW-1:0] r1, r2, u1n;

  always_comb begin
    centred = (b_ctx.op == OP_CENTRED) || (b_ctx.op == OP_THRU_PAR) ||
              (b_ctx.op == OP_THRU_PERP);
    b_foot = (b_ctx.op == OP_FOOT);
    r1 = rnd_p(b_p1, centred);
    r2 = rnd_p(b_p2, centred);
    u1n = b_foot ? (r1 + r2) : r1;
  end

  logic c_valid;
  ctx_t c_ctx;
  rot_t c_c, c_s;
  logic signed [UW-1:0] c_u1, c_u2;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
    if (en) begin
      c_ctx <= b_ctx;
      c_c <= b_c;
      c_s <= b_s;
      c_u1 <= u1n;
      c_u2 <= r2;
    end
  end

  // stage d: foot products
  logic d_valid;
  ctx_t d_ctx;
  logic signed [UW-1:0] d_u1, d_u2;
  logic signed [MPW-1:0] d_m1, d_m2;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= c_valid;
    end
    if (en) begin
      d_ctx <= c_ctx;
      d_u1 <= c_u1;
      d_u2 <= c_u2;
      d_m1 <= c_u1 * c_c;
      d_m2 <= c_u1 * c_s;
    end
  end

  // stage e: endpoints with saturation
  logic d_centred, d_foot;
  coord_t e0, e1, e2, e3;

  always_comb begin
    d_centred = (d_ctx.op == OP_CENTRED) || (d_ctx.op == OP_THRU_PAR) ||
                (d_ctx.op == OP_THRU_PERP);
    d_foot = (d_ctx.op == OP_FOOT);
    e0 = d_ctx.px;
    e1 = d_ctx.py;
    if (d_foot) begin
      e2 = sat(EW'(d_ctx.sx1) + EW'(rnd_m(d_m1)));
      e3 = sat(EW'(d_ctx.sy1) + EW'(rnd_m(d_m2)));
    end else begin
      if (d_centred) begin
        e0 = sat(EW'(d_ctx.px) - EW'(d_u1));
        e1 = sat(EW'(d_ctx.py) - EW'(d_u2));
      end
      e2 = sat(EW'(d_ctx.px) + EW'(d_u1));
      e3 = sat(EW'(d_ctx.py) + EW'(d_u2));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_valid;
    end
    if (en) begin
      ok <= d_ctx.ok;
      end_x1 <= d_ctx.ok ? e0 : '0;
      end_y1 <= d_ctx.ok ? e1 : '0;
      end_x2 <= d_ctx.ok ? e2 : '0;
      end_y2 <= d_ctx.ok ? e3 : '0;
    end
  end

endmodule
`default_nettype wire

/* src/segment_endpoint_construction.sv */
// channel   | handshake                  | payload
// ----------+----------------------------+-----------------------------------------
// item      | item_valid / item_stall    | op, angle_is_degrees, ref_x .. through_y
// result    | result_valid / result_stall| ok, end_x1, end_y1, end_x2, end_y2
//
// one transaction per cycle in, one per cycle out, while no result is held by result_stall
// (6 front stages, 30 vectoring stages, 32 rotation stages, 5 finishing stages)
// reset clears every stage valid bit; no clearing pass
// a stalled result freezes the whole pipeline; item_stall follows result_stall
// while a result is held
`default_nettype none
module segment_endpoint_construction
  import sec_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  output logic         item_stall,
  input  logic [2:0]   op,
  input  logic         angle_is_degrees,
  input  coord_t       ref_x,
  input  coord_t       ref_y,
  input  coord_t       seg_length,
  input  coord_t       angle,
  input  coord_t       seg_x1,
  input  coord_t       seg_y1,
  input  coord_t       seg_x2,
  input  coord_t       seg_y2,
  input  coord_t       through_x,
  input  coord_t       through_y,
  output logic         result_valid,
  input  logic         result_stall,
  output logic         ok,
  output coord_t       end_x1,
  output coord_t       end_y1,
  output coord_t       end_x2,
  output coord_t       end_y2
);

  logic en;
  input_t item;
  logic front_valid, vec_valid, rot_valid;
  vstate_t front_state, vec_state;
  dir_t rot_dir;

  assign en = !(result_valid && result_stall);
  assign item_stall = !en;

  always_comb begin
    item.op = op;
    item.deg = angle_is_degrees;
    item.px = ref_x;
    item.py = ref_y;
    item.len = seg_length;
    item.ang = angle;
    item.sx1 = seg_x1;
    item.sy1 = seg_y1;
    item.sx2 = seg_x2;
    item.sy2 = seg_y2;
    item.tx = through_x;
    item.ty = through_y;
  end

  sec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid),
    .in_item   (item),
    .out_valid (front_valid),
    .out_state (front_state)
  );

  sec_vector u_vector (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_state  (front_state),
    .out_valid (vec_valid),
    .out_state (vec_state)
  );

  sec_rotate u_rotate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vec_valid),
    .in_state  (vec_state),
    .out_valid (rot_valid),
    .out_dir   (rot_dir)
  );

  sec_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rot_valid),
    .in_dir    (rot_dir),
    .out_valid (result_valid),
    .ok        (ok),
    .end_x1    (end_x1),
    .end_y1    (end_y1),
    .end_x2    (end_x2),
    .end_y2    (end_y2)
  );

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> (end_x1 == '0) && (end_y1 == '0) &&
                            (end_x2 == '0) && (end_y2 == '0))
    else $error("failed construction with nonzero endpoints");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(vec_valid) && $stable(rot_valid))
    else $error("pipeline moved while result held");

endmodule
`default_nettype wire
